@@ rtl/core/sm3_pkg.sv @@
// sm3 hash engine shared package
// types, constants and helper functions used by all rtl/core modules
`timescale 1ns / 1ps
`default_nettype none
package sm3_pkg;

	typedef struct packed {
		logic [31:0] message_word;
		logic [2:0]  valid_bytes;
		logic        end_of_message;
	} msg_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        digest_last;
	} dig_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ABSORB,
		ST_PAD80,
		ST_PADZ,
		ST_PADLEN,
		ST_LOAD,
		ST_ROUND,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		SRC_MSG,
		SRC_PAD,
		SRC_ZERO,
		SRC_LEN
	} byte_src_t;

	typedef struct packed {
		logic      word_latch;
		logic      byte_we;
		byte_src_t src;
		logic [1:0] byte_idx;
		logic      len_latch;
		logic      load;
		logic      round;
		logic      restart;
		logic [2:0] sel;
	} cmd_t;

	typedef struct packed {
		logic [5:0] off;
		logic       rnd_last;
	} stat_t;

	localparam logic [31:0] T_LOW = 32'h79CC4519;
	localparam logic [31:0] T_HIGH = 32'h7A879D8A;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] OFF_LAST = 6'd63;
	localparam logic [5:0] OFF_LEN = 6'd56;
	localparam logic [2:0] WORD_LAST = 3'd7;
	localparam logic [2:0] MAX_BYTES = 3'd4;

	localparam logic [31:0] IV [8] = '{
		32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
		32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
	};

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [31:0] perm0(input logic [31:0] x);
		return x ^ rotl(x, 9) ^ rotl(x, 17);
	endfunction

	function automatic logic [31:0] perm1(input logic [31:0] x);
		return x ^ rotl(x, 15) ^ rotl(x, 23);
	endfunction

	// round constant rotated left by the round number modulo 32
	function automatic logic [31:0] tconst(input logic [5:0] j);
		logic [63:0] dbl;
		dbl = (j < 6'd16) ? {T_LOW, T_LOW} : {T_HIGH, T_HIGH};
		dbl = dbl << j[4:0];
		return dbl[63:32];
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/sm3_hash_engine_top.sv @@
// sm3 hash engine top level
// joins sm3_ctrl and sm3_dp; uses sm3_pkg
//
// usage:
// - msg channel: one request carries a big-endian 32-bit word, a count of
//   leading valid bytes (counts above 4 act as 4) and an end-of-message flag
// - dig channel: after the flagged request, eight digest words come out,
//   most significant first, digest_last set on the eighth
// - each request is accepted in idle, then its valid bytes are written one
//   at a time; a full 64-byte block then loads the schedule and runs 64
//   rounds in the single round unit
// - the final request then writes the padding byte, zero bytes up to the
//   length field and the length bytes up to the block end, and runs one or
//   two compressions before the first digest word
// - msg_stall stays high while the block works on a request or shows a digest
// - when the receiver stalls, the digest word holds and the engine waits
// - reset loads the initial value, clears the bit count and leaves the
//   engine idle; the block buffer content is undefined until written
`timescale 1ns / 1ps
`default_nettype none
module sm3_hash_engine_top
	import sm3_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic msg_valid,
	output logic      msg_stall,
	input  wire msg_t msg,
	output logic      dig_valid,
	input  wire logic dig_stall,
	output dig_t      dig
);

	cmd_t cmd;
	stat_t st;

	sm3_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg       (msg),
		.msg_stall (msg_stall),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.st        (st),
		.cmd       (cmd)
	);

	sm3_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.cmd    (cmd),
		.st     (st),
		.dig    (dig)
	);

endmodule
`default_nettype wire

@@ rtl/core/sm3_ctrl.sv @@
// sm3 controller state machine
// sequences byte absorb, padding, compression and digest output; uses sm3_pkg
`timescale 1ns / 1ps
`default_nettype none
module sm3_ctrl
	import sm3_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  msg_valid,
	input  wire msg_t  msg,
	output logic       msg_stall,
	output logic       dig_valid,
	input  wire logic  dig_stall,
	input  wire stat_t st,
	output cmd_t       cmd
);

	state_t state_q, state_d, ret_q, after_d;
	logic [1:0] k_q;
	logic [2:0] n_q, cnt;
	logic last_q;
	logic [2:0] idx_q;
	logic off63, k_end;

	assign cnt = (msg.valid_bytes > MAX_BYTES) ? MAX_BYTES : msg.valid_bytes;
	assign off63 = st.off == OFF_LAST;
	assign k_end = ({1'b0, k_q} + 3'd1) == n_q;

	always_comb begin
		state_d = state_q;
		after_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (msg_valid) begin
					if (cnt != 3'd0) state_d = ST_ABSORB;
					else if (msg.end_of_message) state_d = ST_PAD80;
				end
			end
			ST_ABSORB: begin
				after_d = k_end ? (last_q ? ST_PAD80 : ST_IDLE) : ST_ABSORB;
				state_d = off63 ? ST_LOAD : after_d;
			end
			ST_PAD80: begin
				after_d = ST_PADZ;
				state_d = off63 ? ST_LOAD : after_d;
			end
			ST_PADZ: begin
				after_d = ST_PADZ;
				if (st.off == OFF_LEN) state_d = ST_PADLEN;
				else state_d = off63 ? ST_LOAD : after_d;
			end
			ST_PADLEN: begin
				after_d = ST_OUT;
				state_d = off63 ? ST_LOAD : ST_PADLEN;
			end
			ST_LOAD: state_d = ST_ROUND;
			ST_ROUND: begin
				if (st.rnd_last) state_d = ret_q;
			end
			ST_OUT: begin
				if (!dig_stall && idx_q == WORD_LAST) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		msg_stall = state_q != ST_IDLE;
		dig_valid = state_q == ST_OUT;
		cmd = '0;
		cmd.src = SRC_MSG;
		cmd.byte_idx = k_q;
		cmd.sel = idx_q;
		unique case (state_q)
			ST_IDLE: cmd.word_latch = msg_valid;
			ST_ABSORB: cmd.byte_we = 1'b1;
			ST_PAD80: begin
				cmd.byte_we = 1'b1;
				cmd.src = SRC_PAD;
				cmd.len_latch = 1'b1;
			end
			ST_PADZ: begin
				cmd.byte_we = st.off != OFF_LEN;
				cmd.src = SRC_ZERO;
			end
			ST_PADLEN: begin
				cmd.byte_we = 1'b1;
				cmd.src = SRC_LEN;
			end
			ST_LOAD: cmd.load = 1'b1;
			ST_ROUND: cmd.round = 1'b1;
			ST_OUT: cmd.restart = !dig_stall && idx_q == WORD_LAST;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			k_q <= '0;
			n_q <= '0;
			last_q <= 1'b0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && msg_valid) begin
				k_q <= '0;
				n_q <= cnt;
				last_q <= msg.end_of_message;
				idx_q <= '0;
			end
			if (state_q == ST_ABSORB) k_q <= k_q + 2'd1;
			if (state_d == ST_LOAD) ret_q <= after_d;
			if (state_q == ST_OUT && !dig_stall) idx_q <= idx_q + 3'd1;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/sm3_dp.sv @@
// sm3 datapath: block buffer, bit count, message schedule window and round unit
// driven by sm3_ctrl commands; uses sm3_pkg
`timescale 1ns / 1ps
`default_nettype none
module sm3_dp
	import sm3_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire msg_t msg,
	input  wire cmd_t cmd,
	output stat_t     st,
	output dig_t      dig
);

	logic [31:0] wbuf_q [16];
	logic [31:0] win_q [16];
	logic [31:0] cv_q [8];
	logic [31:0] v_q [8];
	logic [31:0] v_d [8];
	logic [63:0] cnt_q, len_q, len_sh;
	logic [31:0] word_q, word_sh;
	logic [5:0] rnd_q, off;
	logic [7:0] bval;
	logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, wnew;

	assign off = cnt_q[8:3];
	assign st.off = off;
	assign st.rnd_last = rnd_q == OFF_LAST;
	assign dig.digest_word = cv_q[cmd.sel];
	assign dig.digest_last = cmd.sel == WORD_LAST;

	assign word_sh = word_q >> {~cmd.byte_idx, 3'b000};
	assign len_sh = len_q >> {~off[2:0], 3'b000};

	always_comb begin
		case (cmd.src)
			SRC_MSG: bval = word_sh[7:0];
			SRC_PAD: bval = PAD_BYTE;
			SRC_LEN: bval = len_sh[7:0];
			default: bval = '0;
		endcase
	end

	always_comb begin
		a12 = rotl(v_q[0], 12);
		ss1 = rotl(a12 + v_q[4] + tconst(rnd_q), 7);
		ss2 = ss1 ^ a12;
		if (rnd_q < 6'd16) begin
			ff = v_q[0] ^ v_q[1] ^ v_q[2];
			gg = v_q[4] ^ v_q[5] ^ v_q[6];
		end else begin
			ff = (v_q[0] & v_q[1]) | (v_q[0] & v_q[2]) | (v_q[1] & v_q[2]);
			gg = (v_q[4] & v_q[5]) | (~v_q[4] & v_q[6]);
		end
		tt1 = ff + v_q[3] + ss2 + (win_q[0] ^ win_q[4]);
		tt2 = gg + v_q[7] + ss1 + win_q[0];
		v_d[0] = tt1;
		v_d[1] = v_q[0];
		v_d[2] = rotl(v_q[1], 9);
		v_d[3] = v_q[2];
		v_d[4] = perm0(tt2);
		v_d[5] = v_q[4];
		v_d[6] = rotl(v_q[5], 19);
		v_d[7] = v_q[6];
		wnew = perm1(win_q[0] ^ win_q[7] ^ rotl(win_q[13], 15)) ^ rotl(win_q[3], 7)
			^ win_q[10];
	end

	always_ff @(posedge clk) begin
		if (cmd.word_latch) word_q <= msg.message_word;
		if (cmd.len_latch) len_q <= cnt_q;
		if (cmd.byte_we) wbuf_q[off[5:2]][{~off[1:0], 3'b000} +: 8] <= bval;
		if (cmd.load) begin
			for (int i = 0; i < 16; i++) win_q[i] <= wbuf_q[i];
			for (int i = 0; i < 8; i++) v_q[i] <= cv_q[i];
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i + 1];
			win_q[15] <= wnew;
			for (int i = 0; i < 8; i++) v_q[i] <= v_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rnd_q <= '0;
			for (int i = 0; i < 8; i++) cv_q[i] <= IV[i];
		end else begin
			if (cmd.restart) cnt_q <= '0;
			else if (cmd.byte_we) cnt_q <= cnt_q + 64'd8;
			if (cmd.load) rnd_q <= '0;
			else if (cmd.round) rnd_q <= rnd_q + 6'd1;
			if (cmd.restart) begin
				for (int i = 0; i < 8; i++) cv_q[i] <= IV[i];
			end else if (cmd.round && st.rnd_last) begin
				for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] ^ v_d[i];
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/sm3_checker.sv @@
// port-level checker for sm3_hash_engine_top and its bind
// uses sm3_pkg
`timescale 1ns / 1ps
`default_nettype none
module sm3_checker
	import sm3_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic msg_valid,
	input wire logic msg_stall,
	input wire msg_t msg,
	input wire logic dig_valid,
	input wire logic dig_stall,
	input wire dig_t dig
);

	a_dig_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && dig_stall |=> dig_valid && $stable(dig))
		else $error("digest changed while stalled");

	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> msg_stall)
		else $error("request taken during digest output");

	a_no_fast_dig: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && !msg_stall |=> !dig_valid)
		else $error("digest right after a request");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig_stall && dig.digest_last |=> !dig_valid && !msg_stall)
		else $error("output continued after last digest word");

endmodule

bind sm3_hash_engine_top sm3_checker u_chk (.*);
`default_nettype wire
